### rtl/icn_pkg.sv
`default_nettype none

package icn_pkg;

	// register map, index = paddr[4:2]
	localparam logic [2:0] REG_WIDTH      = 3'd0;
	localparam logic [2:0] REG_HEIGHT     = 3'd1;
	localparam logic [2:0] REG_COEF_TOP   = 3'd2;
	localparam logic [2:0] REG_COEF_MID   = 3'd3;
	localparam logic [2:0] REG_COEF_BOT   = 3'd4;

	localparam logic [10:0] WIDTH_RESET  = 11'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;
	localparam logic [23:0] COEF_EDGE_RESET = 24'h010201;
	localparam logic [23:0] COEF_MID_RESET  = 24'h020402;

	localparam int PIXEL_BITS = 8;
	localparam int COEF_BITS  = 8;
	localparam int PROD_BITS  = PIXEL_BITS + COEF_BITS + 1;
	localparam int VALUE_BITS = 20;
	localparam int WEIGHT_BITS = 12;
	// magnitudes seen by the divider
	localparam int MAG_BITS  = VALUE_BITS - 1;
	localparam int WMAG_BITS = WEIGHT_BITS - 1;
	localparam int CNT_BITS  = $clog2(MAG_BITS);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_READ = 6'b000010,
		ST_SUM  = 6'b000100,
		ST_NORM = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic signed [COEF_BITS-1:0] coef_at(input logic [23:0] row,
			input logic [1:0] kc);
		logic signed [COEF_BITS-1:0] c;
		case (kc)
			2'd0: c = signed'(row[7:0]);
			2'd1: c = signed'(row[15:8]);
			2'd2: c = signed'(row[23:16]);
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/icn_div.sv
`default_nettype none

module icn_div
	import icn_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [MAG_BITS-1:0]   dividend,
	input  wire logic [WMAG_BITS-1:0]  divisor,
	output div_stat_t                  stat,
	output logic [MAG_BITS-1:0]        quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [WMAG_BITS-1:0] rem_q;
	logic [MAG_BITS-1:0]  quo_q;
	logic [WMAG_BITS-1:0] div_q;

	logic [WMAG_BITS:0]   trial;
	logic [WMAG_BITS:0]   diff;
	logic                 ge;
	logic [WMAG_BITS-1:0] rem_n;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[MAG_BITS-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};
	assign rem_n = ge ? diff[WMAG_BITS-1:0] : trial[WMAG_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(MAG_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[MAG_BITS-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

### rtl/image_conv_3x3_normalized.sv
`default_nettype none

// 3x3 normalized convolution over a raster stream of 8-bit grayscale pixels.
// Each output pixel is the convolution with the flipped kernel held in the
// three coefficient registers (signed bytes, column 0 in the low byte), with
// zero padding at the borders, divided by the sum of the nine coefficients
// (truncated toward zero), or left undivided when that sum is zero. Output
// (r,c) appears once the input at raster position r*W+c+W+1 has been taken,
// so a frame of W*H pixels needs W+1 trailing items (tuser high) to flush;
// tlast marks the frame's last output, and the next item starts a new frame.
// Writing the width or height register restarts the frame. Two line memories
// of MAX_WIDTH entries hold the previous two rows; no clearing pass is needed
// since entries from outside the current frame are always masked. Each
// item is read from the line memories when it is taken and written back
// in the next; an item that yields no output then returns to idle. An item
// that yields an output also goes through the sum state, the normalize
// state, the bit-serial divider and an output load; with a zero kernel
// weight the divider is skipped. With a nonzero kernel weight the
// divider sets the rate of output items. The next input item is taken while
// a finished output still waits in the output register.

module image_conv_3x3_normalized
	import icn_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// apb configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input items
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel
	input  wire logic        s_axis_tuser,   // [0] is_pad
	// output items
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [19:0] value, [23:20] zero
	output logic             m_axis_tlast    // frame_end
);

	localparam int CB   = $clog2(MAX_WIDTH);
	localparam int RB   = $clog2(MAX_HEIGHT);
	localparam int WCMP = (CB > 11) ? CB : 11;
	localparam int HCMP = (RB > 13) ? RB : 13;
	localparam logic [10:0] WLIM = (MAX_WIDTH > 2047) ? 11'd2047 : 11'(MAX_WIDTH);
	localparam logic [12:0] HLIM = (MAX_HEIGHT > 8191) ? 13'd8191 : 13'(MAX_HEIGHT);

	// configuration registers
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [23:0] coef_q [3];
	logic        cfg_wr;
	logic [10:0] eff_w;
	logic [12:0] eff_h;

	// raster position of the next input and of the next output
	logic [CB-1:0] col_q;
	logic [1:0]    row_q;         // saturates at two
	logic [CB-1:0] ec_q;
	logic [RB-1:0] er_q;

	state_t state_q;

	// item in flight
	logic                  emit_q;
	logic                  last_q;
	logic [PIXEL_BITS-1:0] sample_q;
	logic [CB-1:0]         addr_q;
	logic                  top_ok_q;
	logic                  bot_ok_q;
	logic                  lft_ok_q;
	logic                  rgt_ok_q;

	// line memories: a holds the row above, b the row above that
	logic [PIXEL_BITS-1:0] line_a_mem [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] line_b_mem [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] rda_q;
	logic [PIXEL_BITS-1:0] rdb_q;

	// delayed taps, per kernel row
	logic [PIXEL_BITS-1:0] d1_q [3];
	logic [PIXEL_BITS-1:0] d2_q [3];
	logic [PIXEL_BITS-1:0] cur  [3];

	logic signed [PROD_BITS-1:0]   prod_q [9];
	logic signed [VALUE_BITS-1:0]  sum_q;
	logic signed [WEIGHT_BITS-1:0] weight_q;
	logic signed [VALUE_BITS-1:0]  sum_c;
	logic signed [WEIGHT_BITS-1:0] weight_c;
	logic [VALUE_BITS-1:0]         res_q;

	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] out_value_q;
	logic                  out_last_q;

	logic in_fire;
	logic emit;
	logic col_last;
	logic ec_last;
	logic er_last;
	logic out_load;

	div_stat_t             div_stat;
	logic                  div_start;
	logic [VALUE_BITS-1:0] sum_abs;
	logic [WEIGHT_BITS-1:0] weight_abs;
	logic [MAG_BITS-1:0]   quotient;
	logic                  res_neg;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RESET;
			height_q  <= HEIGHT_RESET;
			coef_q[0] <= COEF_EDGE_RESET;
			coef_q[1] <= COEF_MID_RESET;
			coef_q[2] <= COEF_EDGE_RESET;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_WIDTH:    width_q   <= pwdata[10:0];
				REG_HEIGHT:   height_q  <= pwdata[12:0];
				REG_COEF_TOP: coef_q[0] <= pwdata[23:0];
				REG_COEF_MID: coef_q[1] <= pwdata[23:0];
				REG_COEF_BOT: coef_q[2] <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_WIDTH:    prdata = {21'd0, width_q};
			REG_HEIGHT:   prdata = {19'd0, height_q};
			REG_COEF_TOP: prdata = {8'd0, coef_q[0]};
			REG_COEF_MID: prdata = {8'd0, coef_q[1]};
			REG_COEF_BOT: prdata = {8'd0, coef_q[2]};
			default:      prdata = '0;
		endcase
	end

	// out-of-range sizes clamp
	assign eff_w = (width_q == '0) ? 11'd1 : (width_q > WLIM) ? WLIM : width_q;
	assign eff_h = (height_q == '0) ? 13'd1 : (height_q > HLIM) ? HLIM : height_q;

	// ---------------------------------------------------------------- position
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign col_last = WCMP'(col_q) == WCMP'(eff_w - 11'd1);
	assign ec_last  = WCMP'(ec_q) == WCMP'(eff_w - 11'd1);
	assign er_last  = HCMP'(er_q) == HCMP'(eff_h - 13'd1);
	// first output once the input one row and one pixel past the origin arrives
	assign emit     = (row_q == 2'd2) || (row_q == 2'd1 && col_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ec_q  <= '0;
			er_q  <= '0;
		end else if (cfg_wr && (paddr[4:2] == REG_WIDTH || paddr[4:2] == REG_HEIGHT)) begin
			col_q <= '0;
			row_q <= '0;
			ec_q  <= '0;
			er_q  <= '0;
		end else if (in_fire) begin
			if (emit && ec_last && er_last) begin
				// frame done, next item starts a new one
				col_q <= '0;
				row_q <= '0;
				ec_q  <= '0;
				er_q  <= '0;
			end else begin
				if (emit) begin
					if (ec_last) begin
						ec_q <= '0;
						er_q <= er_q + 1'b1;
					end else begin
						ec_q <= ec_q + 1'b1;
					end
				end
				if (col_last) begin
					col_q <= '0;
					if (row_q != 2'd2) begin
						row_q <= row_q + 2'd1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequencer
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
	assign div_start = (state_q == ST_NORM) && (weight_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			emit_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_READ;
						emit_q  <= emit;
					end
				end
				ST_READ: state_q <= emit_q ? ST_SUM : ST_IDLE;
				ST_SUM:  state_q <= ST_NORM;
				ST_NORM: state_q <= (weight_q == '0) ? ST_OUT : ST_DIV;
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture and line memory read
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= s_axis_tuser ? '0 : s_axis_tdata;
			addr_q   <= col_q;
			last_q   <= ec_last && er_last;
			top_ok_q <= !er_last;
			bot_ok_q <= er_q != '0;
			lft_ok_q <= !ec_last;
			rgt_ok_q <= ec_q != '0;
			rda_q    <= line_a_mem[col_q];
			rdb_q    <= line_b_mem[col_q];
		end
	end

	// write back: current sample moves into a, the old a entry into b
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			line_a_mem[addr_q] <= sample_q;
			line_b_mem[addr_q] <= rda_q;
		end
	end

	assign cur[0] = sample_q;
	assign cur[1] = rda_q;
	assign cur[2] = rdb_q;

	// masked products and window shift
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			for (int kr = 0; kr < 3; kr++) begin
				for (int kc = 0; kc < 3; kc++) begin
					logic [PIXEL_BITS-1:0] px;
					logic                  ok;
					px = (kc == 0) ? cur[kr] : (kc == 1) ? d1_q[kr] : d2_q[kr];
					ok = ((kr == 0) ? top_ok_q : (kr == 2) ? bot_ok_q : 1'b1) &&
						((kc == 0) ? lft_ok_q : (kc == 2) ? rgt_ok_q : 1'b1);
					prod_q[kr*3+kc] <= ok ?
						PROD_BITS'(signed'({1'b0, px}) * coef_at(coef_q[kr], 2'(kc))) : '0;
				end
				d1_q[kr] <= cur[kr];
				d2_q[kr] <= d1_q[kr];
			end
		end
	end

	always_comb begin
		sum_c    = '0;
		weight_c = '0;
		for (int t = 0; t < 9; t++) begin
			sum_c = sum_c + VALUE_BITS'(prod_q[t]);
		end
		for (int kr = 0; kr < 3; kr++) begin
			for (int kc = 0; kc < 3; kc++) begin
				weight_c = weight_c + WEIGHT_BITS'(coef_at(coef_q[kr], 2'(kc)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SUM) begin
			sum_q    <= sum_c;
			weight_q <= weight_c;
		end
	end

	// ---------------------------------------------------------------- normalize
	assign sum_abs    = sum_q[VALUE_BITS-1] ? VALUE_BITS'(-sum_q) : sum_q;
	assign weight_abs = weight_q[WEIGHT_BITS-1] ? WEIGHT_BITS'(-weight_q) : weight_q;

	icn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_abs[MAG_BITS-1:0]),
		.divisor  (weight_abs[WMAG_BITS-1:0]),
		.stat     (div_stat),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_NORM) begin
			res_q   <= sum_q;
			res_neg <= sum_q[VALUE_BITS-1] ^ weight_q[WEIGHT_BITS-1];
		end else if (state_q == ST_DIV && div_stat.done) begin
			res_q <= res_neg ? VALUE_BITS'(-{1'b0, quotient}) : {1'b0, quotient};
		end
	end

	// ---------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= res_q;
			out_last_q  <= last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_value_q};
	assign m_axis_tlast  = out_last_q;

	// ---------------------------------------------------------------- checks
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> !s_axis_tready)
		else $error("input taken while divider busy");

	a_wb_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> WCMP'(addr_q) < WCMP'(eff_w))
		else $error("line memory write beyond row width");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && !m_axis_tready)
		|=> (out_valid_q && state_q == ST_OUT && $stable(out_value_q)))
		else $error("pending output overwritten");

endmodule

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

module tb_top;
	import icn_pkg::*;

	localparam int PX_DEPTH    = 4096 * 1024 + 2048;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [7:0] pixel;
		logic       is_pad;
	} pix_item_t;

	typedef struct {
		logic [19:0] value;
		logic        frame_end;
	} conv_out_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
	logic [7:0]  s_axis_tdata;    // [7:0] pixel
	logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
	logic [23:0] m_axis_tdata;    // [19:0] value, [23:20] zero

	image_conv_3x3_normalized DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// predictor copy of the block's registers and frame position
	logic [10:0] cfg_width;
	logic [12:0] cfg_height;
	logic [23:0] cfg_top, cfg_mid, cfg_bot;
	int          in_pos;          // raster position of the next input item in the frame
	bit   [7:0]  frame_px [PX_DEPTH];

	pix_item_t pix_queue[$];
	conv_out_t conv_expect_q[$];
	int        errors;
	int        cycles;
	bit        no_idle;           // stretches with no gaps on either side
	int        hold_off;          // long receiver stall request

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int eff_w();
		if (cfg_width == 0) return 1;
		if (cfg_width > 1024) return 1024;
		return cfg_width;
	endfunction

	function automatic int eff_h();
		if (cfg_height == 0) return 1;
		if (cfg_height > 4096) return 4096;
		return cfg_height;
	endfunction

	// take one pixel item, queue the convolved output it releases (if any)
	task automatic conv_accept(input pix_item_t it);
		int w, h, p, r, c, pr, pc, kr, kc, k, wt;
		longint acc, res;
		logic [23:0] row;
		conv_out_t o;
		w = eff_w();
		h = eff_h();
		frame_px[in_pos] = it.is_pad ? 8'd0 : it.pixel;
		// output p is released by the input w+1 positions later
		if (in_pos >= w + 1) begin
			p = in_pos - w - 1;
			r = p / w;
			c = p % w;
			acc = 0;
			wt = 0;
			for (kr = 0; kr < 3; kr++) begin
				row = (kr == 0) ? cfg_top : (kr == 1) ? cfg_mid : cfg_bot;
				for (kc = 0; kc < 3; kc++) begin
					k = $signed(row[8*kc +: 8]);
					wt += k;
					pr = r + 1 - kr;
					pc = c + 1 - kc;
					// zero padding outside the frame
					if (pr >= 0 && pr < h && pc >= 0 && pc < w)
						acc += longint'(frame_px[pr*w + pc]) * k;
				end
			end
			// zero weight leaves the sum undivided; division truncates toward zero
			res = (wt != 0) ? acc / wt : acc;
			o.value = res[19:0];
			o.frame_end = (p + 1 == w * h);
			conv_expect_q = {conv_expect_q, o};
			in_pos = o.frame_end ? 0 : in_pos + 1;
		end else begin
			in_pos++;
		end
	endtask

	// input side: one item per handshake, random gap before each
	int in_gap;
	always @(posedge clk or negedge arst_n) begin
		logic      nvalid;
		pix_item_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
			in_gap = 0;
		end else begin
			nvalid = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				conv_accept('{pixel: s_axis_tdata, is_pad: s_axis_tuser});
				nvalid = 1'b0;
			end
			if (!nvalid) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (pix_queue.size() > 0) begin
					nxt = pix_queue.pop_front();
					s_axis_tdata <= nxt.pixel;
					s_axis_tuser <= nxt.is_pad;
					nvalid = 1'b1;
					in_gap = no_idle ? 0 : $urandom_range(0, 8);
				end
			end
			s_axis_tvalid <= nvalid;
		end
	end

	// output side: compare against oldest expectation, random stalls
	int out_stall;
	always @(posedge clk or negedge arst_n) begin
		conv_out_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			out_stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (conv_expect_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected output item value=%h last=%b", $time,
						m_axis_tdata[19:0], m_axis_tlast);
				end else begin
					e = conv_expect_q.pop_front();
					if (m_axis_tdata[19:0] !== e.value) begin
						errors++;
						$display("%0t: value mismatch expected %h actual %h", $time,
							e.value, m_axis_tdata[19:0]);
					end
					if (m_axis_tlast !== e.frame_end) begin
						errors++;
						$display("%0t: frame_end mismatch expected %b actual %b", $time,
							e.frame_end, m_axis_tlast);
					end
				end
				out_stall = no_idle ? 0 : $urandom_range(0, 8);
			end
			if (hold_off > 0) begin
				hold_off--;
				m_axis_tready <= 1'b0;
			end else if (out_stall > 0) begin
				out_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// wait for the block to drain; items with no output may still be in flight
	task automatic wait_idle();
		while (pix_queue.size() > 0 || s_axis_tvalid || conv_expect_q.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_WIDTH:    begin cfg_width  = val[10:0]; in_pos = 0; end
			REG_HEIGHT:   begin cfg_height = val[12:0]; in_pos = 0; end
			REG_COEF_TOP: cfg_top = val[23:0];
			REG_COEF_MID: cfg_mid = val[23:0];
			default:      cfg_bot = val[23:0];
		endcase
	endtask

	// new image size and kernel, block idle
	task automatic set_phase(input int w, input int h, input logic [23:0] t,
			input logic [23:0] m, input logic [23:0] b);
		wait_idle();
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_COEF_TOP, t);
		reg_write(REG_COEF_MID, m);
		reg_write(REG_COEF_BOT, b);
	endtask

	// append one item to the driver's pending list
	task automatic add_pixel(input pix_item_t it);
		pix_queue = {pix_queue, it};
	endtask

	// mode 0 random, 1 all 255, 2 all 0
	task automatic push_frame(input int mode, input int pad_pct);
		int i, n;
		pix_item_t it;
		n = eff_w() * eff_h();
		for (i = 0; i < n; i++) begin
			it.pixel  = (mode == 1) ? 8'hFF : (mode == 2) ? 8'h00 : 8'($urandom);
			// pad inside the frame counts as a zero pixel
			it.is_pad = ($urandom_range(0, 99) < pad_pct);
			add_pixel(it);
		end
		// flush items, pixel content ignored
		for (i = 0; i <= eff_w(); i++)
			add_pixel('{pixel: 8'($urandom), is_pad: 1'b1});
	endtask

	task automatic push_raw(input int n);
		repeat (n) add_pixel('{pixel: 8'($urandom), is_pad: 1'($urandom)});
	endtask

	function automatic logic [23:0] rand_row();
		if ($urandom_range(0, 2) == 0) return 24'($urandom_range(0, 3) * 24'h010101);
		return 24'($urandom);
	endfunction

	initial begin
		int total, f, nf;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		errors = 0; cycles = 0; no_idle = 1'b0; hold_off = 0;
		cfg_width = WIDTH_RESET; cfg_height = HEIGHT_RESET;
		cfg_top = COEF_EDGE_RESET; cfg_mid = COEF_MID_RESET; cfg_bot = COEF_EDGE_RESET;
		in_pos = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset kernel on a tiny all-white frame, then extremes
		set_phase(3, 3, COEF_EDGE_RESET, COEF_MID_RESET, COEF_EDGE_RESET);
		push_frame(1, 0);
		// most negative coefficients, all-white pixels
		set_phase(3, 2, 24'h808080, 24'h808080, 24'h808080);
		push_frame(1, 0);
		// largest positive coefficients
		set_phase(2, 2, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
		push_frame(1, 0);
		// zero weight kernel: raw sum passes through undivided
		set_phase(3, 3, 24'h00FF00, 24'hFF04FF, 24'h00FF00);
		push_frame(0, 20);
		// zero width and height act as one pixel
		set_phase(0, 0, 24'h000001, 24'h000100, 24'h030000);
		push_frame(0, 0);
		push_frame(2, 0);
		// width above maximum clamps to 1024, partial frame with one output
		set_phase(2047, 1, 24'h020100, 24'hFD0504, 24'h000000);
		push_raw(1026);
		// height above maximum clamps, partial frame
		set_phase(1, 8191, 24'h010101, 24'h010101, 24'h010101);
		push_raw(40);

		// random frames
		total = 0;
		while (total < 200) begin
			set_phase($urandom_range(1, 12), $urandom_range(1, 8),
				rand_row(), rand_row(), rand_row());
			no_idle = ($urandom_range(0, 3) == 0);
			// one long receiver hold while items keep coming
			if (total == 0) hold_off = 400;
			nf = $urandom_range(1, 3);
			for (f = 0; f < nf; f++) begin
				push_frame(0, $urandom_range(0, 1) ? 0 : 15);
				total += eff_w() * eff_h() + eff_w() + 1;
			end
			// stray items begin a new frame that the next write cuts off
			if ($urandom_range(0, 3) == 0) push_raw($urandom_range(1, 6));
		end
		no_idle = 1'b0;

		wait_idle();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
rtl/icn_pkg.sv
rtl/icn_div.sv
rtl/image_conv_3x3_normalized.sv
tb/tb_top.sv
